>>> rtl/bst_pkg.sv
// Package for the bounded set table: request and result word types, mode codes
// and default sizes. It depends on nothing else and is used by every module.
`timescale 1ns / 1ps

package bst_pkg;

    // Default number of entries the set can hold.
    localparam int C_CAPACITY = 16;

    // Widths of the result fields, which the word format fixes.
    localparam int C_POS_W = 4;
    localparam int C_CNT_W = 5;
    localparam int C_VAL_W = 32;

    // Request modes.
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [C_VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic               success;
        logic [C_POS_W-1:0] position;
        logic [C_CNT_W-1:0] element_count;
    } t_out_word;

    // Access strobes from the sequencer to the element memory.
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

>>> rtl/bst_mem.sv
// Element memory of the bounded set table: one write port and one read port
// with registered read data. Depends on bst_pkg.
`timescale 1ns / 1ps

module bst_mem #(
    parameter int DEPTH = bst_pkg::C_CAPACITY,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  bst_pkg::t_mem_ctl           i_ctl,
    input  logic [IDX_W-1:0]            i_wr_addr,
    input  logic [bst_pkg::C_VAL_W-1:0] i_wr_data,
    input  logic [IDX_W-1:0]            i_rd_addr,
    output logic [bst_pkg::C_VAL_W-1:0] o_rd_data
);
    import bst_pkg::*;

    logic [C_VAL_W-1:0] r_mem [DEPTH];
    logic [C_VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/bst_ctrl.sv
// Sequencer of the bounded set table: scans the element memory, appends,
// compacts on removal and keeps the count. Depends on bst_pkg.
`timescale 1ns / 1ps

module bst_ctrl #(
    parameter int CAPACITY = bst_pkg::C_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_vld,
    output logic                        o_in_stall,
    input  bst_pkg::t_in_word           i_in_word,
    output logic                        o_res_vld,
    input  logic                        i_res_stall,
    output bst_pkg::t_out_word          o_res_word,
    output bst_pkg::t_mem_ctl           o_mem_ctl,
    output logic [IDX_W-1:0]            o_mem_wr_addr,
    output logic [bst_pkg::C_VAL_W-1:0] o_mem_wr_data,
    output logic [IDX_W-1:0]            o_mem_rd_addr,
    input  logic [bst_pkg::C_VAL_W-1:0] i_mem_rd_data
);
    import bst_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]         r_state,    n_state;
    logic [1:0]         r_mode,     n_mode;
    logic [C_VAL_W-1:0] r_val,      n_val;
    logic [CNT_W-1:0]   r_count,    n_count;
    logic [CNT_W-1:0]   r_addr,     n_addr;
    logic               r_pend,     n_pend;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]   r_slot,     n_slot;
    t_out_word          r_res,      n_res;

    logic               w_hit;
    logic               w_fin;
    logic               w_ok;
    logic [IDX_W-1:0]   w_pos;
    logic [IDX_W+C_POS_W-1:0] w_pos_ext;
    logic [CNT_W+C_CNT_W-1:0] w_cnt_ext;

    assign w_hit = r_pend && (i_mem_rd_data == r_val);

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_val      = r_val;
        n_count    = r_count;
        n_addr     = r_addr;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_slot     = r_slot;
        n_res      = r_res;
        w_fin      = 1'b0;
        w_ok       = 1'b0;
        w_pos      = '0;
        o_mem_ctl     = '0;
        o_mem_rd_addr = r_addr[IDX_W-1:0];
        o_mem_wr_addr = r_count[IDX_W-1:0];
        o_mem_wr_data = r_val;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_vld) begin
                    n_mode = i_in_word.mode;
                    n_val  = i_in_word.value;
                    n_addr = '0;
                    if (i_in_word.mode == MODE_CLEAR) begin
                        n_count = '0;
                        w_ok    = 1'b1;
                        w_fin   = 1'b1;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!w_hit && (r_addr < r_count)) begin
                    // Keep one read in flight while the previous word is compared.
                    o_mem_ctl.rd = 1'b1;
                    n_pend       = 1'b1;
                    n_pend_idx   = r_addr[IDX_W-1:0];
                    n_addr       = CNT_W'(r_addr + 1'b1);
                end else begin
                    case (r_mode)
                        MODE_ADD: begin
                            if (!w_hit && (r_count < CNT_W'(CAPACITY))) begin
                                o_mem_ctl.wr = 1'b1;
                                w_ok    = 1'b1;
                                w_pos   = r_count[IDX_W-1:0];
                                n_count = CNT_W'(r_count + 1'b1);
                            end
                            w_fin = 1'b1;
                        end
                        MODE_REMOVE: begin
                            if (w_hit) begin
                                n_slot  = r_pend_idx;
                                n_addr  = CNT_W'(r_pend_idx) + CNT_W'(1);
                                n_state = ST_SHIFT;
                            end else begin
                                w_fin = 1'b1;
                            end
                        end
                        default: begin
                            w_ok  = w_hit;
                            w_pos = w_hit ? r_pend_idx : '0;
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                // Each entry read above the removed slot is written one place lower.
                if (r_pend) begin
                    o_mem_ctl.wr  = 1'b1;
                    o_mem_wr_addr = IDX_W'(r_pend_idx - 1'b1);
                    o_mem_wr_data = i_mem_rd_data;
                end
                if (r_addr < r_count) begin
                    o_mem_ctl.rd = 1'b1;
                    n_pend       = 1'b1;
                    n_pend_idx   = r_addr[IDX_W-1:0];
                    n_addr       = CNT_W'(r_addr + 1'b1);
                end else if (!r_pend) begin
                    n_count = CNT_W'(r_count - 1'b1);
                    w_ok    = 1'b1;
                    w_pos   = r_slot;
                    w_fin   = 1'b1;
                end
            end
            ST_RESP: begin
                if (!i_res_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        w_pos_ext = {{C_POS_W{1'b0}}, w_pos};
        w_cnt_ext = {{C_CNT_W{1'b0}}, n_count};
        if (w_fin) begin
            n_state             = ST_RESP;
            n_res.success       = w_ok;
            n_res.position      = w_pos_ext[C_POS_W-1:0];
            n_res.element_count = w_cnt_ext[C_CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_val      <= n_val;
        r_addr     <= n_addr;
        r_pend_idx <= n_pend_idx;
        r_slot     <= n_slot;
        r_res      <= n_res;
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_res_vld  = (r_state == ST_RESP);
    assign o_res_word = r_res;

endmodule

>>> rtl/bounded_set_table_top.sv
// Top level of the bounded set table: sequencer, element memory and output
// register. Depends on bst_pkg, bst_ctrl and bst_mem.
`timescale 1ns / 1ps

// The bounded set table keeps up to CAPACITY distinct 32-bit values in the
// order they were added. Each input word carries a mode (add, remove, lookup,
// clear) and a value; each yields exactly one output word with success, the
// slot concerned and the number of elements held afterwards.
// Both channels use valid and stall: a word moves on a rising edge where valid
// is high and stall is low.
// One request is handled at a time. An add, a lookup or a remove scans the
// held entries from slot zero until the value matches or the count is reached.
// A successful remove then compacts: each entry above the removed slot is read
// and written one slot lower. A clear only resets the count. The element
// memory has a single read port and is scanned one entry per cycle. With a
// free output the next request is taken as soon as the result has left the
// sequencer.
// The output register lets the sequencer take the next request while a result
// still waits; if the receiver keeps stalling, the following result is held in
// the sequencer and the input stalls until the output register drains.
// Reset empties the set (count zero) and clears the sequencer state, pending
// flag and output valid; memory is read only below the count, so is not cleared.
module bounded_set_table_top #(
    parameter int CAPACITY = bst_pkg::C_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_vld,
    output logic               o_in_stall,
    input  bst_pkg::t_in_word  i_in_word,
    output logic               o_out_vld,
    input  logic               i_out_stall,
    output bst_pkg::t_out_word o_out_word
);
    import bst_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_mem_ctl           w_mem_ctl;
    logic [IDX_W-1:0]   w_mem_wr_addr;
    logic [C_VAL_W-1:0] w_mem_wr_data;
    logic [IDX_W-1:0]   w_mem_rd_addr;
    logic [C_VAL_W-1:0] w_mem_rd_data;

    logic               w_res_vld;
    logic               w_res_stall;
    t_out_word          w_res_word;

    logic               r_out_vld;
    t_out_word          r_out_word;

    bst_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_vld      (i_in_vld),
        .o_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .o_res_vld     (w_res_vld),
        .i_res_stall   (w_res_stall),
        .o_res_word    (w_res_word),
        .o_mem_ctl     (w_mem_ctl),
        .o_mem_wr_addr (w_mem_wr_addr),
        .o_mem_wr_data (w_mem_wr_data),
        .o_mem_rd_addr (w_mem_rd_addr),
        .i_mem_rd_data (w_mem_rd_data)
    );

    bst_mem #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data),
        .i_rd_addr (w_mem_rd_addr),
        .o_rd_data (w_mem_rd_data)
    );

    // The output register takes a new result whenever it is empty or its word
    // is being taken in the same cycle.
    assign w_res_stall = r_out_vld && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!w_res_stall) begin
            r_out_vld <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld && !w_res_stall) begin
            r_out_word <= w_res_word;
        end
    end

    assign o_out_vld  = r_out_vld;
    assign o_out_word = r_out_word;

    // One request at a time: an accepted word always stalls the input next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_vld && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a request was still in progress");

    // A result held back by the output register stays offered unchanged.
    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_vld && w_res_stall) |=> (w_res_vld && $stable(w_res_word)))
        else $error("pending result dropped or changed while stalled");

    // The memory is never touched while the sequencer waits for a request.
    a_mem_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall) |-> (w_mem_ctl == '0))
        else $error("memory access while the sequencer is idle");

    // A new output word only appears when the sequencer offered one.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_vld) |-> $past(w_res_vld))
        else $error("output word appeared without a result");

endmodule

>>> test/bounded_set_table_top_tb.sv
// Self-checking testbench for bounded_set_table_top. It drives request words,
// predicts each result word with its own model of the set, and checks them in order.
// Depends on bst_pkg and the bounded_set_table_top RTL.
`timescale 1ns / 1ps

import bst_pkg::*;

// Holds a copy of the set and the result words that are still to come.
class set_table_ledger;
    logic [C_VAL_W-1:0] shadow_elems[C_CAPACITY];
    int                 shadow_held;
    t_out_word          pending_results[$];
    int                 mismatches;
    int                 mode_seen[4];
    int                 hits;
    int                 full_rejects;
    int                 dup_rejects;
    int                 peak_held;

    function new();
        shadow_held  = 0;
        mismatches   = 0;
        hits         = 0;
        full_rejects = 0;
        dup_rejects  = 0;
        peak_held    = 0;
        foreach (mode_seen[m]) mode_seen[m] = 0;
    endfunction

    // Applies an accepted request word to the copy of the set and queues the
    // result word that the block must return for it.
    function void note_request(t_in_word w);
        t_out_word exp_w;
        bit        found;
        int        slot;
        int        i;
        found = 1'b0;
        slot  = 0;
        for (i = 0; i < shadow_held; i++) begin
            if (!found && shadow_elems[i] == w.value) begin
                found = 1'b1;
                slot  = i;
            end
        end
        exp_w.success = 1'b0;
        case (w.mode)
            MODE_ADD: begin
                if (found) begin
                    dup_rejects++;
                    slot = 0;
                end else if (shadow_held >= C_CAPACITY) begin
                    full_rejects++;
                    slot = 0;
                end else begin
                    shadow_elems[shadow_held] = w.value;
                    slot = shadow_held;
                    shadow_held++;
                    exp_w.success = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (found) begin
                    for (i = slot; i + 1 < shadow_held; i++)
                        shadow_elems[i] = shadow_elems[i + 1];
                    shadow_held--;
                    exp_w.success = 1'b1;
                end
            end
            MODE_LOOKUP: begin
                exp_w.success = found;
            end
            MODE_CLEAR: begin
                shadow_held   = 0;
                slot          = 0;
                exp_w.success = 1'b1;
            end
        endcase
        exp_w.position      = slot[C_POS_W-1:0];
        exp_w.element_count = shadow_held[C_CNT_W-1:0];
        mode_seen[w.mode]++;
        if (exp_w.success) hits++;
        if (shadow_held > peak_held) peak_held = shadow_held;
        pending_results.push_back(exp_w);
    endfunction

    // Compares one accepted result word with the oldest expectation.
    function void check_result(t_out_word got);
        t_out_word exp_w;
        if (pending_results.size() == 0) begin
            $error("result word with nothing expected: %p", got);
            mismatches++;
            return;
        end
        exp_w = pending_results.pop_front();
        if (got.success !== exp_w.success) begin
            $error("success: expected %0d, got %0d", exp_w.success, got.success);
            mismatches++;
        end
        if (got.position !== exp_w.position) begin
            $error("position: expected %0d, got %0d", exp_w.position, got.position);
            mismatches++;
        end
        if (got.element_count !== exp_w.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   exp_w.element_count, got.element_count);
            mismatches++;
        end
    endfunction

    function int outstanding();
        return pending_results.size();
    endfunction

    function bit clean();
        if (pending_results.size() != 0)
            $error("%0d result words never arrived", pending_results.size());
        return mismatches == 0 && pending_results.size() == 0;
    endfunction
endclass

module bounded_set_table_top_tb;

    localparam int N_RANDOM  = 1750;
    // Well beyond the time the slowest request takes.
    localparam int DRAIN_CYC = 2 * C_CAPACITY + 8;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_vld     = 1'b0;
    t_in_word  in_word    = '0;
    logic      out_stall  = 1'b0;
    logic      in_stall;
    logic      out_vld;
    t_out_word out_word;

    // While set, neither side idles, so the block runs back to back.
    bit        calm       = 1'b0;

    set_table_ledger ledger;

    bounded_set_table_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_vld    (in_vld),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_vld   (out_vld),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest correct run, which is under a tenth of this.
    initial begin
        #5_000_000;
        $display("FAIL bounded_set_table_top");
        $finish;
    end

    // Offers one request word, with a random idle gap first, and returns once
    // the block has taken it. Valid stays high across back-to-back words, so
    // it is never lowered and raised in the same time step.
    task automatic send_word(input logic [1:0] mode, input logic [C_VAL_W-1:0] value);
        t_in_word w;
        w.mode  = mode;
        w.value = value;
        while (!calm && $urandom_range(99) < 12) begin
            in_vld <= 1'b0;
            @(posedge i_clk);
        end
        in_vld  <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (in_stall);
        ledger.note_request(w);
    endtask

    // Result side: checks each word taken and stalls at random, except in the
    // calm stretch. Values read just after the edge are those the block saw.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_vld && !out_stall)
                ledger.check_result(out_word);
            out_stall <= !calm && ($urandom_range(99) < 12);
        end
    end

    initial begin
        logic [C_VAL_W-1:0] pool[40];
        int                 pool_n;
        int                 add_w;
        int                 rem_w;
        int                 clr_w;
        int                 sent;
        int                 pick;
        int                 k;
        logic [1:0]         mode;
        logic [C_VAL_W-1:0] value;

        ledger = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty-set misses, the value extremes, a duplicate add,
        // removal at the front, middle and end, and clear with stale entries.
        send_word(MODE_LOOKUP, 32'h0000_0000);
        send_word(MODE_REMOVE, 32'h0000_0000);
        send_word(MODE_ADD,    32'h8000_0000);
        send_word(MODE_ADD,    32'h7fff_ffff);
        send_word(MODE_ADD,    32'h0000_0000);
        send_word(MODE_ADD,    32'hffff_ffff);
        send_word(MODE_ADD,    32'd20);
        send_word(MODE_ADD,    32'h7fff_ffff);
        send_word(MODE_LOOKUP, 32'h8000_0000);
        send_word(MODE_LOOKUP, 32'd20);
        send_word(MODE_LOOKUP, 32'h7fff_fffe);
        send_word(MODE_REMOVE, 32'h0000_0000);
        send_word(MODE_LOOKUP, 32'd20);
        send_word(MODE_REMOVE, 32'h5555_5555);
        send_word(MODE_REMOVE, 32'd20);
        send_word(MODE_REMOVE, 32'h8000_0000);
        send_word(MODE_LOOKUP, 32'hffff_ffff);
        send_word(MODE_CLEAR,  32'haaaa_aaaa);
        send_word(MODE_LOOKUP, 32'hffff_ffff);
        send_word(MODE_ADD,    32'hffff_ffff);
        send_word(MODE_CLEAR,  32'h5555_5555);
        send_word(MODE_CLEAR,  32'h0000_0000);

        // Random part, in episodes. Each episode draws values from a small pool
        // so that duplicates, hits and a full set all occur; pools larger than
        // the capacity with a heavy add weight drive the set to full. A few
        // values come straight from the generator as noise.
        sent = 0;
        while (sent < N_RANDOM) begin
            pool_n = $urandom_range(40, 3);
            for (k = 0; k < pool_n; k++) begin
                case ($urandom_range(9))
                    0:       pool[k] = 32'h8000_0000;
                    1:       pool[k] = 32'h7fff_ffff;
                    2:       pool[k] = $urandom_range(20);
                    3:       pool[k] = -$urandom_range(20);
                    default: pool[k] = $urandom();
                endcase
            end
            add_w = $urandom_range(80, 30);
            rem_w = $urandom_range(30, 10);
            clr_w = $urandom_range(4);
            for (k = 0; k < 60 && sent < N_RANDOM; k++) begin
                calm = (sent >= 700 && sent < 1000);
                pick = $urandom_range(99);
                if (pick < clr_w)
                    mode = MODE_CLEAR;
                else if (pick < clr_w + add_w)
                    mode = MODE_ADD;
                else if (pick < clr_w + add_w + rem_w)
                    mode = MODE_REMOVE;
                else
                    mode = MODE_LOOKUP;
                if ($urandom_range(9) == 0)
                    value = $urandom();
                else
                    value = pool[$urandom_range(pool_n - 1)];
                send_word(mode, value);
                sent++;
            end
        end
        calm = 1'b0;
        in_vld <= 1'b0;

        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Covered %0d adds, %0d removes, %0d lookups and %0d clears; %0d succeeded.",
                 ledger.mode_seen[MODE_ADD], ledger.mode_seen[MODE_REMOVE],
                 ledger.mode_seen[MODE_LOOKUP], ledger.mode_seen[MODE_CLEAR], ledger.hits);
        $display("Set reached %0d entries; %0d adds refused as full, %0d as duplicates.",
                 ledger.peak_held, ledger.full_rejects, ledger.dup_rejects);
        if (ledger.clean())
            $display("PASS bounded_set_table_top");
        else
            $display("FAIL bounded_set_table_top");
        $finish;
    end

endmodule

>>> sim.f
rtl/bst_pkg.sv
rtl/bst_mem.sv
rtl/bst_ctrl.sv
rtl/bounded_set_table_top.sv
test/bounded_set_table_top_tb.sv
